@@ sv/mlpf_pkg.sv @@
// Shared types, codes and constants of the perceptron inference block.
`default_nettype none
package mlpf_pkg;

  localparam int MaxLayersDef = 4;
  localparam int MaxWidthDef  = 64;
  localparam int ValueBits    = 16;
  localparam int AccBits      = 40;
  localparam int WidthRegs    = 4;
  localparam int ResultCap    = 64;

  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_BIAS   = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
  localparam logic [2:0] REG_L1_WIDTH    = 3'd2;
  localparam logic [2:0] REG_L2_WIDTH    = 3'd3;
  localparam logic [2:0] REG_L3_WIDTH    = 3'd4;
  localparam logic [2:0] REG_L4_WIDTH    = 3'd5;
  localparam logic [2:0] REG_HIDDEN_RELU = 3'd6;

  typedef struct packed {
    logic [1:0]              action;
    logic [1:0]              layer_sel;
    logic [5:0]              row;
    logic [5:0]              col;
    logic signed [ValueBits-1:0] value;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  neuron;
    logic [12:0] activation;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic                    wr_en;
    logic [5:0]              wr_row;
    logic [5:0]              wr_col;
    logic [1:0]              wr_layer;
    logic signed [ValueBits-1:0] wr_data;
    logic [1:0]              layer;
    logic                    clear;
    logic                    shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                    wr_en;
    logic [5:0]              wr_row;
    logic [1:0]              wr_layer;
    logic signed [ValueBits-1:0] wr_data;
    logic [1:0]              layer;
    logic                    relu;
  } post_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_SHIFT,
    ST_POST,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

@@ sv/mlpf_cell.sv @@
// One MAC cell of the chain: owns the weights of one output neuron.
`default_nettype none
module mlpf_cell #(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_WIDTH  = 64,
  parameter int IDX        = 0,
  parameter int IW         = $clog2(MAX_WIDTH)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  mlpf_pkg::cell_ctrl_t     ctrl_i,
  input  wire                      in_v_i,
  input  wire  signed [15:0]       in_a_i,
  input  wire  [IW-1:0]            in_col_i,
  output logic                     out_v_o,
  output logic signed [15:0]       out_a_o,
  output logic [IW-1:0]            out_col_o,
  input  wire  signed [39:0]       acc_i,
  output logic signed [39:0]       acc_o
);
  import mlpf_pkg::*;

  localparam int Depth = MAX_LAYERS * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);

  logic signed [15:0] mem [Depth];
  logic               in_v_q, s1_v_q, s2_v_q;
  logic signed [15:0] in_a_q, s1_a_q, rd_q;
  logic [IW-1:0]      in_col_q;
  logic signed [31:0] prod_q;
  logic signed [39:0] acc_q, acc_d;
  logic signed [40:0] sum;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [31:0]        wr_full, rd_full;

  assign wr_full = 32'(ctrl_i.wr_layer) * MAX_WIDTH + 32'(ctrl_i.wr_col);
  assign rd_full = 32'(ctrl_i.layer) * MAX_WIDTH + 32'(in_col_q);
  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && (32'(ctrl_i.wr_row) == IDX)) begin
      mem[wr_addr] <= ctrl_i.wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // saturating accumulate of the product stream; clear zeroes it, shift loads acc_i
  always_comb begin
    sum = 41'(acc_q) + 41'(prod_q);
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.shift) begin
      acc_d = acc_i;
    end else if (s2_v_q) begin
      if (sum[40] != sum[39]) begin
        acc_d = sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
        acc_d = sum[39:0];
      end
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      in_v_q <= in_v_i;
      s1_v_q <= in_v_q;
      s2_v_q <= s1_v_q;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_a_q   <= in_a_i;
    in_col_q <= in_col_i;
    s1_a_q   <= in_a_q;
    prod_q   <= rd_q * s1_a_q;
  end

  assign out_v_o   = in_v_q;
  assign out_a_o   = in_a_q;
  assign out_col_o = in_col_q;
  assign acc_o     = acc_q;

endmodule
`default_nettype wire

@@ sv/mlpf_post.sv @@
// Post stage: bias add, rounding to Q4.12 and ReLU or sigmoid activation.
`default_nettype none
module mlpf_post #(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_WIDTH  = 64,
  parameter int IW         = $clog2(MAX_WIDTH)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  mlpf_pkg::post_ctrl_t     ctrl_i,
  input  wire                      in_v_i,
  input  wire  signed [39:0]       in_acc_i,
  input  wire  [IW-1:0]            in_idx_i,
  output logic                     out_v_o,
  output logic [IW-1:0]            out_idx_o,
  output logic signed [15:0]       out_act_o
);
  import mlpf_pkg::*;

  localparam int Depth = MAX_LAYERS * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam logic [11:0] SigTab [33] = '{
    12'd2048, 12'd2303, 12'd2550, 12'd2782, 12'd2994, 12'd3184, 12'd3349,
    12'd3490, 12'd3608, 12'd3705, 12'd3785, 12'd3850, 12'd3902, 12'd3943,
    12'd3976, 12'd4002, 12'd4022, 12'd4038, 12'd4051, 12'd4061, 12'd4069,
    12'd4075, 12'd4079, 12'd4083, 12'd4086, 12'd4088, 12'd4090, 12'd4091,
    12'd4092, 12'd4093, 12'd4094, 12'd4094, 12'd4095
  };

  logic signed [15:0] bmem [Depth];
  logic signed [15:0] bias_q;
  logic [31:0]        wr_full, rd_full;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [IW-1:0]      i1_q, i2_q, i3_q, i4_q;
  logic signed [39:0] acc1_q, z40_q;
  logic signed [15:0] z16_q, act_q;
  logic signed [40:0] bsum, rsum;
  logic signed [28:0] rq;
  logic [16:0]        mag;
  logic [15:0]        mclip;
  logic [5:0]         sidx;
  logic [9:0]         frac;
  logic [11:0]        t0, t1, y;
  logic [7:0]         dlt;
  logic [18:0]        interp;
  logic [12:0]        sig;
  logic signed [15:0] act_d;

  assign wr_full = 32'(ctrl_i.wr_layer) * MAX_WIDTH + 32'(ctrl_i.wr_row);
  assign rd_full = 32'(ctrl_i.layer) * MAX_WIDTH + 32'(in_idx_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      bmem[wr_full[AW-1:0]] <= ctrl_i.wr_data;
    end
    bias_q <= bmem[rd_full[AW-1:0]];
  end

  // bias enters as b * 4096, then saturate to the accumulator width; round to Q4.12
  always_comb begin
    bsum = 41'(acc1_q) + 41'($signed({bias_q, 12'd0}));
    rsum = 41'(z40_q) + 41'sd2048;
    rq   = rsum[40:12];
  end

  // ReLU, or sigmoid: clamp |z| to 8.0, interpolate between table points
  always_comb begin
    mag   = z16_q[15] ? (17'd0 - 17'(z16_q)) : 17'(z16_q);
    mclip = (mag > 17'd32768) ? 16'd32768 : mag[15:0];
    sidx  = mclip[15:10];
    frac  = mclip[9:0];
    t0    = SigTab[(sidx >= 6'd32) ? 6'd32 : sidx];
    t1    = SigTab[(sidx >= 6'd32) ? 6'd32 : sidx + 6'd1];
    dlt   = 8'(t1 - t0);
    interp = 19'(dlt) * 19'(frac) + 19'd512;
    y     = (sidx >= 6'd32) ? SigTab[32] : t0 + 12'(interp[18:10]);
    sig   = z16_q[15] ? (13'd4096 - 13'(y)) : 13'(y);
    if (ctrl_i.relu) begin
      act_d = z16_q[15] ? 16'sd0 : z16_q;
    end else begin
      act_d = $signed({3'd0, sig});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc1_q <= in_acc_i;
    i1_q   <= in_idx_i;
    i2_q   <= i1_q;
    i3_q   <= i2_q;
    i4_q   <= i3_q;
    if (bsum[40] != bsum[39]) begin
      z40_q <= bsum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      z40_q <= bsum[39:0];
    end
    if (rq > 29'sd32767) begin
      z16_q <= 16'sh7fff;
    end else if (rq < -29'sd32768) begin
      z16_q <= 16'sh8000;
    end else begin
      z16_q <= rq[15:0];
    end
    act_q <= act_d;
  end

  assign out_v_o   = v4_q;
  assign out_idx_o = i4_q;
  assign out_act_o = act_q;

endmodule
`default_nettype wire

@@ sv/mlp_forward_inference.sv @@
// Top level: dense perceptron inference engine built on a chain of MAC cells.
//
// Use: write the registers on the APB port while the block is idle, then send
// in-beats. A weight beat (action 0) or bias beat (action 1) loads a store;
// every weight and bias a sample touches must be loaded first. Sample beats
// (action 2) write one input element each; the beat with last_element set
// starts the forward pass, during which in_ready_o stays low.
// Each layer streams its n_in inputs into the head of a chain of MAX_WIDTH
// cells; every cell owns one output neuron, multiplies the passing element
// by its weight and accumulates with saturation. The chain fills (FEED) and
// drains (DRAIN), then the sums shift out (SHIFT) through the bias/activation
// stage and the POST state flushes it before the next layer or the emit.
// After the output layer, one out-beat per output neuron follows in index
// order, each read from the activation buffer read port once the previous
// beat is taken; the final beat has last set. A stalled receiver holds the
// output register and the emit sequence pauses; nothing is dropped. The block
// accepts in-beats again once the final result sits in the output register.
// Reset clears the control state and the registers to their defaults; the
// weight, bias and activation stores are not cleared and need no sweep.
`default_nettype none
module mlp_forward_inference #(
  parameter int MAX_LAYERS = mlpf_pkg::MaxLayersDef,
  parameter int MAX_WIDTH  = mlpf_pkg::MaxWidthDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  mlpf_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output mlpf_pkg::out_item_t   out_data_o,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [4:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import mlpf_pkg::*;

  localparam int CW        = $clog2(MAX_WIDTH + 1);
  localparam int DW        = $clog2(MAX_WIDTH + 8);
  localparam int IW        = $clog2(MAX_WIDTH);
  localparam int BW        = $clog2(2 * MAX_WIDTH);
  localparam int LMax      = (MAX_LAYERS < WidthRegs) ? MAX_LAYERS : WidthRegs;
  localparam int DrainLast = MAX_WIDTH + 4;
  localparam int PostLast  = 5;

  // configuration registers
  logic [2:0] layer_count_q;
  logic [6:0] input_width_q, l1_width_q, l2_width_q, l3_width_q, l4_width_q;
  logic       hidden_relu_q;
  logic       cfg_wr;

  state_e          state_q, state_d;
  logic [1:0]      layer_q, layer_d;
  logic [DW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   w_in, w_out, emit_n, w_in0;
  logic [1:0]      nl_m1;
  logic            last_layer;
  logic            in_acc, in_ready, do_clear, do_shift, do_feed, emit_go;
  logic            feed_v_q, rd_pend_q, out_valid_q;
  logic [IW-1:0]   feed_col_q;
  logic [CW-1:0]   emit_idx_q;
  out_item_t       out_q;

  logic signed [15:0] buf_mem [2*MAX_WIDTH];
  logic signed [15:0] buf_rd_q, buf_wdata;
  logic [BW-1:0]      buf_raddr, buf_waddr;
  logic               buf_we, sample_wr;
  logic               half;

  cell_ctrl_t         cctrl;
  post_ctrl_t         pctrl;
  logic               post_v;
  logic [IW-1:0]      post_idx;
  logic signed [15:0] post_act;

  function automatic logic [CW-1:0] clamp_w(logic [6:0] w);
    if (w == 7'd0) return CW'(1);
    if (32'(w) > MAX_WIDTH) return CW'(MAX_WIDTH);
    return CW'(w);
  endfunction

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 3'd1;
      input_width_q <= 7'd1;
      l1_width_q    <= 7'd1;
      l2_width_q    <= 7'd1;
      l3_width_q    <= 7'd1;
      l4_width_q    <= 7'd1;
      hidden_relu_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LAYER_COUNT: layer_count_q <= pwdata[2:0];
        REG_INPUT_WIDTH: input_width_q <= pwdata[6:0];
        REG_L1_WIDTH:    l1_width_q    <= pwdata[6:0];
        REG_L2_WIDTH:    l2_width_q    <= pwdata[6:0];
        REG_L3_WIDTH:    l3_width_q    <= pwdata[6:0];
        REG_L4_WIDTH:    l4_width_q    <= pwdata[6:0];
        REG_HIDDEN_RELU: hidden_relu_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LAYER_COUNT: prdata = 32'(layer_count_q);
      REG_INPUT_WIDTH: prdata = 32'(input_width_q);
      REG_L1_WIDTH:    prdata = 32'(l1_width_q);
      REG_L2_WIDTH:    prdata = 32'(l2_width_q);
      REG_L3_WIDTH:    prdata = 32'(l3_width_q);
      REG_L4_WIDTH:    prdata = 32'(l4_width_q);
      REG_HIDDEN_RELU: prdata = 32'(hidden_relu_q);
      default:         prdata = '0;
    endcase
  end

  // layer geometry for the layer in flight
  always_comb begin
    w_in0 = clamp_w(input_width_q);
    unique case (layer_q)
      2'd0: begin
        w_in  = w_in0;
        w_out = clamp_w(l1_width_q);
      end
      2'd1: begin
        w_in  = clamp_w(l1_width_q);
        w_out = clamp_w(l2_width_q);
      end
      2'd2: begin
        w_in  = clamp_w(l2_width_q);
        w_out = clamp_w(l3_width_q);
      end
      default: begin
        w_in  = clamp_w(l3_width_q);
        w_out = clamp_w(l4_width_q);
      end
    endcase
    if (layer_count_q == 3'd0) begin
      nl_m1 = 2'd0;
    end else if (32'(layer_count_q) > LMax) begin
      nl_m1 = 2'(LMax - 1);
    end else begin
      nl_m1 = 2'(layer_count_q - 3'd1);
    end
    last_layer = (layer_q == nl_m1);
    emit_n     = (32'(w_out) > ResultCap) ? CW'(ResultCap) : w_out;
  end

  assign in_acc = in_valid_i && in_ready;

  // next state, layer and step counter
  always_comb begin
    state_d = state_q;
    layer_d = layer_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc && in_data_i.action == ACT_SAMPLE && in_data_i.last_element) begin
          state_d = ST_FEED;
          layer_d = 2'd0;
        end
      end
      ST_FEED: begin
        if (32'(cnt_q) + 1 == 32'(w_in)) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + DW'(1);
        end
      end
      ST_DRAIN: begin
        if (32'(cnt_q) == DrainLast) begin
          state_d = ST_SHIFT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + DW'(1);
        end
      end
      ST_SHIFT: begin
        if (32'(cnt_q) + 1 == 32'(w_out)) begin
          state_d = ST_POST;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + DW'(1);
        end
      end
      ST_POST: begin
        if (32'(cnt_q) == PostLast) begin
          cnt_d = '0;
          if (last_layer) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_FEED;
            layer_d = layer_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + DW'(1);
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          cnt_d = cnt_q + DW'(1);
        end
        if (rd_pend_q && (32'(emit_idx_q) + 1 == 32'(emit_n))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // per-state controls
  always_comb begin
    in_ready = 1'b0;
    do_clear = 1'b0;
    do_shift = 1'b0;
    do_feed  = 1'b0;
    emit_go  = 1'b0;
    half     = ~layer_q[0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        do_clear = 1'b1;
      end
      ST_FEED: begin
        do_feed = 1'b1;
        half    = layer_q[0];
      end
      ST_SHIFT: do_shift = 1'b1;
      ST_POST:  do_clear = 1'b1;
      ST_EMIT: begin
        emit_go = !out_valid_q && !rd_pend_q && (32'(cnt_q) < 32'(emit_n));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      layer_q     <= 2'd0;
      cnt_q       <= '0;
      feed_v_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      layer_q   <= layer_d;
      cnt_q     <= cnt_d;
      feed_v_q  <= do_feed;
      rd_pend_q <= emit_go;
      // hold the result until the receiver takes it
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    feed_col_q <= cnt_q[IW-1:0];
    if (emit_go) begin
      emit_idx_q <= cnt_q[CW-1:0];
    end
    if (rd_pend_q) begin
      out_q.neuron     <= 6'(emit_idx_q);
      out_q.activation <= buf_rd_q[12:0];
      out_q.last       <= (32'(emit_idx_q) + 1 == 32'(emit_n));
    end
  end

  // activation buffer: input sample in half 0, layers ping-pong between halves
  assign sample_wr = in_acc && (in_data_i.action == ACT_SAMPLE)
                     && (32'(in_data_i.col) < 32'(w_in0));
  assign buf_raddr = BW'(32'(half) * MAX_WIDTH + 32'(cnt_q));
  assign buf_we    = post_v || sample_wr;
  assign buf_waddr = post_v ? BW'(32'(~layer_q[0]) * MAX_WIDTH + 32'(post_idx))
                            : BW'(in_data_i.col);
  assign buf_wdata = post_v ? post_act : in_data_i.value;

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_rd_q <= buf_mem[buf_raddr];
  end

  // load paths and per-layer control
  always_comb begin
    cctrl.wr_en    = in_acc && (in_data_i.action == ACT_WEIGHT)
                     && (32'(in_data_i.layer_sel) < MAX_LAYERS)
                     && (32'(in_data_i.row) < MAX_WIDTH)
                     && (32'(in_data_i.col) < MAX_WIDTH);
    cctrl.wr_row   = in_data_i.row;
    cctrl.wr_col   = in_data_i.col;
    cctrl.wr_layer = in_data_i.layer_sel;
    cctrl.wr_data  = in_data_i.value;
    cctrl.layer    = layer_q;
    cctrl.clear    = do_clear;
    cctrl.shift    = do_shift;

    pctrl.wr_en    = in_acc && (in_data_i.action == ACT_BIAS)
                     && (32'(in_data_i.layer_sel) < MAX_LAYERS)
                     && (32'(in_data_i.row) < MAX_WIDTH);
    pctrl.wr_row   = in_data_i.row;
    pctrl.wr_layer = in_data_i.layer_sel;
    pctrl.wr_data  = in_data_i.value;
    pctrl.layer    = layer_q;
    pctrl.relu     = hidden_relu_q && !last_layer;
  end

  // chain of MAC cells: elements travel right, sums shift left to the head
  logic               chain_v   [MAX_WIDTH+1];
  logic signed [15:0] chain_a   [MAX_WIDTH+1];
  logic [IW-1:0]      chain_col [MAX_WIDTH+1];
  logic signed [39:0] chain_acc [MAX_WIDTH+1];

  assign chain_v[0]           = feed_v_q;
  assign chain_a[0]           = buf_rd_q;
  assign chain_col[0]         = feed_col_q;
  assign chain_acc[MAX_WIDTH] = '0;

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    mlpf_cell #(
      .MAX_LAYERS (MAX_LAYERS),
      .MAX_WIDTH  (MAX_WIDTH),
      .IDX        (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cctrl),
      .in_v_i    (chain_v[k]),
      .in_a_i    (chain_a[k]),
      .in_col_i  (chain_col[k]),
      .out_v_o   (chain_v[k+1]),
      .out_a_o   (chain_a[k+1]),
      .out_col_o (chain_col[k+1]),
      .acc_i     (chain_acc[k+1]),
      .acc_o     (chain_acc[k])
    );
  end

  mlpf_post #(
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pctrl),
    .in_v_i    (do_shift),
    .in_acc_i  (chain_acc[0]),
    .in_idx_i  (cnt_q[IW-1:0]),
    .out_v_o   (post_v),
    .out_idx_o (post_idx),
    .out_act_o (post_act)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ sv/mlpf_checker.sv @@
// Port-level checker for the inference block, bound to the top level.
`default_nettype none
module mlpf_props (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_o,
  input mlpf_pkg::in_item_t   in_data_i,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input mlpf_pkg::out_item_t  out_data_o
);
  import mlpf_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // the closing sample element starts a pass that blocks new beats
  a_pass_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.action == ACT_SAMPLE
      && in_data_i.last_element |=> !in_ready_o)
    else $error("input accepted right after a pass started");

  // sigmoid output stays within 0 to 1.0
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.activation <= 13'd4096)
    else $error("activation above 1.0");

  // more results pending: input stays blocked
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> !in_ready_o)
    else $error("input accepted before the output vector finished");

endmodule

bind mlp_forward_inference mlpf_props u_mlpf_props (.*);
`default_nettype wire

@@ verif/mlpf_checker.sv @@
// Checker for the perceptron inference block: predicts out-beats and compares them.
`timescale 1ns / 1ps
module mlpf_checker (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_ready_i,
  input  mlpf_pkg::in_item_t  in_data_i,
  input  wire                 out_valid_i,
  input  wire                 out_ready_i,
  input  mlpf_pkg::out_item_t out_data_i,
  input  wire                 cfg_we_i,
  input  wire  [2:0]          cfg_idx_i,
  input  wire  [31:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import mlpf_pkg::*;

  localparam int Lmax = 4;
  localparam int Wmax = 64;
  localparam longint AccHi = 64'sd549755813887;
  localparam longint AccLo = -AccHi - 1;

  int sig_lut [33] = '{2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490, 3608, 3705,
    3785, 3850, 3902, 3943, 3976, 4002, 4022, 4038, 4051, 4061, 4069, 4075, 4079,
    4083, 4086, 4088, 4090, 4091, 4092, 4093, 4094, 4094, 4095};

  int      wts    [Lmax][Wmax][Wmax];
  int      biases [Lmax][Wmax];
  int      acts   [2][Wmax];
  bit [2:0] n_layers;
  bit [6:0] dims [5];
  bit       relu_on;
  out_item_t expected_beats [$];

  function automatic longint sat_acc(longint a);
    if (a > AccHi) return AccHi;
    if (a < AccLo) return AccLo;
    return a;
  endfunction

  function automatic longint round_q12(longint a);
    longint t;
    longint r;
    t = a + 2048;
    r = t >>> 12;
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return r;
  endfunction

  function automatic int sigmoid_q12(longint z);
    longint m;
    longint y;
    longint d;
    m = (z < 0) ? -z : z;
    if (m > 32768) m = 32768;
    if ((m >> 10) >= 32) y = sig_lut[32];
    else begin
      d = sig_lut[(m >> 10) + 1] - sig_lut[m >> 10];
      y = sig_lut[m >> 10] + ((d * (m & 1023) + 512) >>> 10);
    end
    return int'((z < 0) ? 4096 - y : y);
  endfunction

  function automatic int eff_width(bit [6:0] w);
    if (w == 0) return 1;
    if (w > Wmax) return Wmax;
    return w;
  endfunction

  // Run the whole forward pass and queue one beat per output neuron.
  task automatic forward_pass();
    int nl;
    int n_in;
    int n_out;
    longint acc;
    longint z;
    nl = n_layers;
    if (nl == 0) nl = 1;
    if (nl > Lmax) nl = Lmax;
    for (int l = 0; l < nl; l++) begin
      n_in = eff_width(dims[l]);
      n_out = eff_width(dims[l + 1]);
      for (int i = 0; i < n_out; i++) begin
        acc = 0;
        for (int p = 0; p < n_in; p++)
          acc = sat_acc(acc + longint'(wts[l][i][p]) * longint'(acts[l % 2][p]));
        acc = sat_acc(acc + longint'(biases[l][i]) * 4096);
        z = round_q12(acc);
        if (l + 1 != nl && relu_on) acts[(l + 1) % 2][i] = (z < 0) ? 0 : int'(z);
        else acts[(l + 1) % 2][i] = sigmoid_q12(z);
      end
      if (l + 1 == nl)
        for (int i = 0; i < n_out; i++)
          expected_beats.push_back('{neuron: i[5:0],
            activation: acts[(l + 1) % 2][i][12:0], last: (i + 1 == n_out)});
    end
  endtask

  assign pending_o = expected_beats.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_beat;
    if (!rst_ni) begin
      n_layers = 1;
      for (int i = 0; i < 5; i++) dims[i] = 1;
      relu_on = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LAYER_COUNT: n_layers = cfg_data_i[2:0];
          REG_INPUT_WIDTH: dims[0] = cfg_data_i[6:0];
          REG_L1_WIDTH:    dims[1] = cfg_data_i[6:0];
          REG_L2_WIDTH:    dims[2] = cfg_data_i[6:0];
          REG_L3_WIDTH:    dims[3] = cfg_data_i[6:0];
          REG_L4_WIDTH:    dims[4] = cfg_data_i[6:0];
          REG_HIDDEN_RELU: relu_on = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("unexpected out-beat %p", out_data_i);
        end else begin
          exp_beat = expected_beats.pop_front();
          if (out_data_i !== exp_beat) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display("mismatch: expected %p got %p", exp_beat, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.action)
          ACT_WEIGHT: wts[in_data_i.layer_sel][in_data_i.row][in_data_i.col] =
                        in_data_i.value;
          ACT_BIAS:   biases[in_data_i.layer_sel][in_data_i.row] = in_data_i.value;
          ACT_SAMPLE: begin
            if (in_data_i.col < eff_width(dims[0]))
              acts[0][in_data_i.col] = in_data_i.value;
            if (in_data_i.last_element) forward_pass();
          end
          default: ;
        endcase
      end
    end
  end
endmodule

@@ verif/tb.sv @@
// Testbench top: drives the perceptron block and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import mlpf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          hold_off = 1'b0;
  bit          hold_go = 1'b0;
  int          burst_left = 0;

  // Current network shape, used to keep samples inside loaded stores.
  int          cur_layers = 1;
  int          cur_dims [5] = '{1, 1, 1, 1, 1};

  always #4 clk_i = ~clk_i;

  mlp_forward_inference u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mlpf_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_idx_i(paddr[4:2]),
    .cfg_data_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Stall the receiver on its own pattern; hold off entirely when asked.
  always @(posedge clk_i) begin
    if (hold_off) out_ready <= 1'b0;
    else if (cycle_count % 512 < 128) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Long receiver hold-off, counted here while the sender keeps offering beats.
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offer one beat and wait for its acceptance; gaps come between bursts.
  task automatic send_beat(in_item_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic logic [15:0] rand_value(int mode);
    case (mode)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  task automatic load_weight(int l, int r, int c, logic [15:0] v);
    send_beat('{action: ACT_WEIGHT, layer_sel: l[1:0], row: r[5:0], col: c[5:0],
                value: v, last_element: 1'($urandom)});
  endtask

  task automatic load_bias(int l, int r, logic [15:0] v);
    send_beat('{action: ACT_BIAS, layer_sel: l[1:0], row: r[5:0],
                col: 6'($urandom), value: v, last_element: 1'($urandom)});
  endtask

  // Fill every weight and bias the current shape reads.
  task automatic load_network(int mode);
    for (int l = 0; l < cur_layers; l++)
      for (int r = 0; r < cur_dims[l + 1]; r++) begin
        for (int c = 0; c < cur_dims[l]; c++) load_weight(l, r, c, rand_value(mode));
        load_bias(l, r, rand_value(mode));
      end
  endtask

  task automatic send_sample(int mode, bit stray);
    for (int c = 0; c < cur_dims[0]; c++)
      send_beat('{action: ACT_SAMPLE, layer_sel: 2'($urandom), row: 6'($urandom),
                  col: c[5:0], value: rand_value(mode),
                  last_element: (c == cur_dims[0] - 1) && !stray});
    // Out-of-range element that still starts the pass.
    if (stray)
      send_beat('{action: ACT_SAMPLE, layer_sel: 2'($urandom), row: 6'($urandom),
                  col: 6'd63, value: rand_value(3), last_element: 1'b1});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_shape(int nl, int d0, int d1, int d2, int d3, int d4, bit relu);
    wait_idle();
    cur_layers = nl;
    cur_dims = '{d0, d1, d2, d3, d4};
    write_reg(REG_LAYER_COUNT, nl);
    write_reg(REG_INPUT_WIDTH, d0);
    write_reg(REG_L1_WIDTH, d1);
    write_reg(REG_L2_WIDTH, d2);
    write_reg(REG_L3_WIDTH, d3);
    write_reg(REG_L4_WIDTH, d4);
    write_reg(REG_HIDDEN_RELU, relu);
  endtask

  initial begin
    int n_samp;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset shape, saturating and zero values, undefined action, stray element.
    load_network(0);
    send_sample(0, 1'b0);
    load_network(1);
    send_sample(0, 1'b0);
    send_sample(1, 1'b0);
    send_beat('{action: 2'd3, layer_sel: 2'd3, row: 6'd63, col: 6'd63,
                value: 16'hFFFF, last_element: 1'b1});
    load_network(2);
    send_sample(2, 1'b1);

    // Fixed shapes with random values, extremes among them; widest one last and only once.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_shape(2, 3, 4, 2, 1, 1, 1'b1);
        1: set_shape(4, 2, 3, 2, 3, 2, 1'b0);
        2: set_shape(3, 4, 2, 3, 2, 1, 1'b1);
        3: set_shape(4, 2, 2, 2, 2, 5, 1'b1);
        4: set_shape(1, 3, 4, 1, 1, 1, 1'b0);
        5: set_shape(2, 2, 2, 1, 1, 1, 1'b0);
        6: set_shape(1, 24, 1, 1, 1, 1, 1'b1);
        default: set_shape(1, 1, 64, 64, 64, 64, 1'b0);
      endcase
      load_network(3);
      n_samp = (ph >= 6) ? 1 : 2;
      for (int s = 0; s < n_samp; s++) begin
        if (ph == 2 && s == 0) hold_go = 1'b1;
        send_sample(3, $urandom_range(0, 7) == 0);
      end
    end
    // Out-of-range register values fold back to legal shapes.
    set_shape(7, 0, 0, 0, 0, 0, 1'b1);
    cur_layers = 4;
    cur_dims = '{1, 1, 1, 1, 1};
    load_network(3);
    for (int s = 0; s < 3; s++) send_sample(3, 1'b0);

    wait_idle();
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
